// ===== hdl/kmq_pkg.sv =====
`timescale 1ns / 1ps

package kmq_pkg;

  // operation codes
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_POLL = 2'd1;
  localparam logic [1:0] FUNC_GET  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_TOO_SMALL = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  // match vector bits examined per scan cycle
  localparam int SCAN_CHUNK = 8;

  typedef struct packed {
    logic       ld_in;       // latch input transaction
    logic       cmp;         // compare all slots against key
    logic       scan;        // examine next chunk of matches
    logic       fetch;       // read matched entry
    logic       push;        // append at tail
    logic       remove;      // drop matched entry, close gap
    logic       rotate;      // move matched entry to head
    logic       out_load;    // load result register
    logic [2:0] res_status;
    logic       res_present;
    logic       res_take;    // return fetched handle/length
  } kmq_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       len_bad;
    logic       cap_bad;
    logic       full;
    logic       hit;
    logic       miss;
    logic       fits;
    logic       out_free;
  } kmq_sts_t;

endpackage

// ===== hdl/kmq_ctrl.sv =====
`timescale 1ns / 1ps

module kmq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kmq_pkg::kmq_sts_t sts,
  output kmq_pkg::kmq_cmd_t cmd
);
  import kmq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] res_code, res_code_next;
  logic       res_present, res_present_next;
  logic       res_take, res_take_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd              = '0;
    state_next       = state;
    res_code_next    = res_code;
    res_present_next = res_present;
    res_take_next    = res_take;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in        = 1'b1;
          res_present_next = 1'b0;
          res_take_next    = 1'b0;
          state_next       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          FUNC_SEND: begin
            if (sts.len_bad) begin
              res_code_next = ST_INVALID;
            end else if (sts.full) begin
              res_code_next = ST_FULL;
            end else begin
              cmd.push      = 1'b1;
              res_code_next = ST_OK;
            end
            state_next = S_RESP;
          end
          FUNC_POLL: begin
            cmd.cmp    = 1'b1;
            state_next = S_SCAN;
          end
          FUNC_GET: begin
            if (sts.cap_bad) begin
              res_code_next = ST_INVALID;
              state_next    = S_RESP;
            end else begin
              cmd.cmp    = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: begin
            res_code_next = ST_INVALID;
            state_next    = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          if (sts.func == FUNC_POLL) begin
            res_code_next    = ST_OK;
            res_present_next = 1'b1;
            state_next       = S_RESP;
          end else begin
            state_next = S_FETCH;
          end
        end else if (sts.miss) begin
          res_code_next = (sts.func == FUNC_POLL) ? ST_OK : ST_NOT_FOUND;
          state_next    = S_RESP;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.fits) begin
          cmd.remove    = 1'b1;
          res_code_next = ST_OK;
          res_take_next = 1'b1;
        end else begin
          cmd.rotate    = 1'b1;
          res_code_next = ST_TOO_SMALL;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.res_status  = res_code;
    cmd.res_present = res_present;
    cmd.res_take    = res_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_code    <= ST_OK;
      res_present <= 1'b0;
      res_take    <= 1'b0;
    end else begin
      state       <= state_next;
      res_code    <= res_code_next;
      res_present <= res_present_next;
      res_take    <= res_take_next;
    end
  end

  // queue is only modified from the states that own those operations
  a_push_in_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (state == S_DECODE) && !sts.full && !sts.len_bad)
    else $error("push outside decode or when full");

  a_modify_after_fetch: assert property (@(posedge clk) disable iff (rst)
    (cmd.remove || cmd.rotate) |-> $past(cmd.fetch))
    else $error("queue reorder without fetched entry");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

endmodule

// ===== hdl/kmq_dp.sv =====
`timescale 1ns / 1ps

module kmq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  kmq_pkg::kmq_cmd_t cmd,
  output kmq_pkg::kmq_sts_t sts,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic [1:0]        func,
  input  logic [31:0]       id,
  input  logic [31:0]       msg_handle,
  input  logic [15:0]       msg_len,
  input  logic [15:0]       capacity,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic              present,
  output logic [31:0]       out_handle,
  output logic [15:0]       out_len
);
  import kmq_pkg::*;

  localparam int IW    = $clog2(QUEUE_DEPTH);
  localparam int OW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CHUNK = (QUEUE_DEPTH < SCAN_CHUNK) ? QUEUE_DEPTH : SCAN_CHUNK;
  localparam int CIW   = $clog2(CHUNK);

  // latched transaction
  logic [1:0]  func_q;
  logic [31:0] id_q, handle_q;
  logic [15:0] len_q, cap_q;

  logic [15:0] max_len;
  logic [OW-1:0] occ;

  logic [31:0] slot_key    [QUEUE_DEPTH];
  logic [31:0] slot_handle [QUEUE_DEPTH];
  logic [15:0] slot_length [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] mvec;
  logic [OW-1:0]          base;
  logic [IW-1:0]          pos;

  // fetched entry
  logic [31:0] ent_key, ent_handle;
  logic [15:0] ent_len;

  logic [CHUNK-1:0]       chunk;
  logic [QUEUE_DEPTH-1:0] rest;
  logic                   chunk_hit;

  function automatic logic [CIW-1:0] first_set(input logic [CHUNK-1:0] v);
    logic [CIW-1:0] r;
    r = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (v[i]) r = CIW'(i);
    end
    return r;
  endfunction

  assign chunk     = mvec[CHUNK-1:0];
  assign rest      = mvec >> CHUNK;
  assign chunk_hit = |chunk;

  assign sts.func     = func_q;
  assign sts.len_bad  = (len_q > max_len);
  assign sts.cap_bad  = (cap_q > max_len);
  assign sts.full     = (occ == OW'(QUEUE_DEPTH));
  assign sts.hit      = chunk_hit;
  assign sts.miss     = !chunk_hit && (rest == '0);
  assign sts.fits     = (ent_len <= cap_q);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.push) begin
      occ <= occ + OW'(1);
    end else if (cmd.remove) begin
      occ <= occ - OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      func_q   <= func;
      id_q     <= id;
      handle_q <= msg_handle;
      len_q    <= msg_len;
      cap_q    <= capacity;
    end
  end

  // chunked priority scan of the match vector
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      base <= '0;
    end else if (cmd.scan) begin
      if (chunk_hit) begin
        pos <= IW'(base + OW'(first_set(chunk)));
      end else begin
        base <= base + OW'(CHUNK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      ent_key    <= slot_key[pos];
      ent_handle <= slot_handle[pos];
      ent_len    <= slot_length[pos];
    end
  end

  // per-slot cells: compare, append, close gap, move to head
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [31:0] up_key, up_handle, dn_key, dn_handle;
    logic [15:0] up_len, dn_len;

    if (g < QUEUE_DEPTH - 1) begin : g_up
      assign up_key    = slot_key[g+1];
      assign up_handle = slot_handle[g+1];
      assign up_len    = slot_length[g+1];
    end else begin : g_up_end
      assign up_key    = slot_key[g];
      assign up_handle = slot_handle[g];
      assign up_len    = slot_length[g];
    end

    if (g > 0) begin : g_dn
      assign dn_key    = slot_key[g-1];
      assign dn_handle = slot_handle[g-1];
      assign dn_len    = slot_length[g-1];
    end else begin : g_dn_head
      assign dn_key    = ent_key;
      assign dn_handle = ent_handle;
      assign dn_len    = ent_len;
    end

    always_ff @(posedge clk) begin
      if (cmd.push && (occ == OW'(g))) begin
        slot_key[g]    <= id_q;
        slot_handle[g] <= handle_q;
        slot_length[g] <= len_q;
      end else if (cmd.remove && (IW'(g) >= pos)) begin
        slot_key[g]    <= up_key;
        slot_handle[g] <= up_handle;
        slot_length[g] <= up_len;
      end else if (cmd.rotate && (IW'(g) <= pos)) begin
        slot_key[g]    <= dn_key;
        slot_handle[g] <= dn_handle;
        slot_length[g] <= dn_len;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.cmp) begin
        mvec[g] <= (slot_key[g] == id_q) && (OW'(g) < occ);
      end else if (cmd.scan) begin
        mvec[g] <= rest[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= cmd.res_status;
      present    <= cmd.res_present;
      out_handle <= cmd.res_take ? ent_handle : 32'd0;
      out_len    <= cmd.res_take ? ent_len : 16'd0;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |=> occ == $past(occ) - OW'(1))
    else $error("remove did not shrink queue");

  a_match_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> (OW'(pos) < occ))
    else $error("matched slot beyond occupancy");

endmodule

// ===== hdl/keyed_message_queue.sv =====
`timescale 1ns / 1ps
// Keyed message queue: ordered queue of (id, handle, length) with keyed get.
// Send and rejected ops skip the scan; poll and get scan the match vector in
// chunks of 8 slots, and a get on a hit then fetches and modifies the entry.
// One transaction in flight: the next is taken once the result is loaded.
// Sync reset: queue empty, max_len = 4096, no result pending; no memory clearing pass.

module keyed_message_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_len
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] id,
  input  logic [31:0] msg_handle,
  input  logic [15:0] msg_len,
  input  logic [15:0] capacity,
  // response channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        present,
  output logic [31:0] out_handle,
  output logic [15:0] out_len
);
  import kmq_pkg::*;

  // Controller sequences each request transaction:
  //   decode -> (compare all slots) -> chunked priority scan -> fetch -> modify
  // Datapath holds the slot cells, occupancy, max_len and the result register.
  // The result register frees the controller: a new request is taken while the
  // previous response still waits on out_ready.
  kmq_cmd_t cmd;
  kmq_sts_t sts;

  kmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .func       (func),
    .id         (id),
    .msg_handle (msg_handle),
    .msg_len    (msg_len),
    .capacity   (capacity),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .present    (present),
    .out_handle (out_handle),
    .out_len    (out_len)
  );

endmodule
